// ===== rtl/apr_pkg.sv =====
// Shared types and constants for the aging page replacement core.
`timescale 1ns / 1ps

package apr_pkg;

    // Default build-time sizes
    localparam int FRAMES_DEF       = 16;
    localparam int COUNTER_BITS_DEF = 8;
    localparam int PAGE_BITS_DEF    = 32;

    // Fixed field widths of the channels and the register
    localparam int ACTIVE_W  = 5;
    localparam int FRAME_W   = 4;
    localparam int PAGE_IN_W = 32;
    localparam int COUNT_W   = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // Command codes of the input channel
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                 cmd;
        logic [PAGE_IN_W-1:0] page_number;
    } access_t;

    // Result transaction
    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 evicted;
        logic [PAGE_IN_W-1:0] evicted_page;
        logic [COUNT_W-1:0]   hit_count;
        logic [COUNT_W-1:0]   miss_count;
    } result_t;

    // Status of a lookup travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic free_found;
        logic min_found;
    } probe_flags_t;

    // Update broadcast to every cell
    typedef struct packed {
        logic tick;
        logic fill;
        logic mark;
    } cell_cmd_t;

endpackage

// ===== rtl/apr_cell.sv =====
// One page frame of the table, with its stage of the lookup chain.
`timescale 1ns / 1ps

module apr_cell #(
    parameter int INDEX        = 0,
    parameter int FRAMES       = apr_pkg::FRAMES_DEF,
    parameter int COUNTER_BITS = apr_pkg::COUNTER_BITS_DEF,
    parameter int PAGE_BITS    = apr_pkg::PAGE_BITS_DEF,
    parameter int IW           = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int UW           = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [UW-1:0]              used_frames,
    input  apr_pkg::cell_cmd_t         cmd,
    input  logic [IW-1:0]              cmd_slot,
    input  logic [PAGE_BITS-1:0]       cmd_page,
    input  apr_pkg::probe_flags_t      probe_flags_i,
    input  logic [PAGE_BITS-1:0]       probe_page_i,
    input  logic [IW-1:0]              probe_hit_idx_i,
    input  logic [IW-1:0]              probe_free_idx_i,
    input  logic [IW-1:0]              probe_min_idx_i,
    input  logic [COUNTER_BITS-1:0]    probe_min_cnt_i,
    input  logic [PAGE_BITS-1:0]       probe_min_page_i,
    output apr_pkg::probe_flags_t      probe_flags_o,
    output logic [PAGE_BITS-1:0]       probe_page_o,
    output logic [IW-1:0]              probe_hit_idx_o,
    output logic [IW-1:0]              probe_free_idx_o,
    output logic [IW-1:0]              probe_min_idx_o,
    output logic [COUNTER_BITS-1:0]    probe_min_cnt_o,
    output logic [PAGE_BITS-1:0]       probe_min_page_o
);
    import apr_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [UW-1:0] MY_POS = UW'(INDEX);

    // Frame state
    logic                    valid_reg, valid_next;
    logic                    ref_reg, ref_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [PAGE_BITS-1:0]    page_reg, page_next;

    // Probe stage
    probe_flags_t            pf_reg, pf_next;
    logic [PAGE_BITS-1:0]    pp_reg, pp_next;
    logic [IW-1:0]           hit_idx_reg, hit_idx_next;
    logic [IW-1:0]           free_idx_reg, free_idx_next;
    logic [IW-1:0]           min_idx_reg, min_idx_next;
    logic [COUNTER_BITS-1:0] min_cnt_reg, min_cnt_next;
    logic [PAGE_BITS-1:0]    min_page_reg, min_page_next;

    logic active;
    logic selected;

    assign active   = (MY_POS < used_frames);
    assign selected = (cmd_slot == MY_IDX);

    // Lookup: first match, first free, first smallest counter
    always_comb begin
        pf_next       = probe_flags_i;
        pp_next       = probe_page_i;
        hit_idx_next  = probe_hit_idx_i;
        free_idx_next = probe_free_idx_i;
        min_idx_next  = probe_min_idx_i;
        min_cnt_next  = probe_min_cnt_i;
        min_page_next = probe_min_page_i;
        if (probe_flags_i.valid && active) begin
            if (valid_reg && (page_reg == probe_page_i) && !probe_flags_i.hit) begin
                pf_next.hit  = 1'b1;
                hit_idx_next = MY_IDX;
            end
            if (!valid_reg && !probe_flags_i.free_found) begin
                pf_next.free_found = 1'b1;
                free_idx_next      = MY_IDX;
            end
            if (valid_reg && (!probe_flags_i.min_found || (cnt_reg < probe_min_cnt_i))) begin
                pf_next.min_found = 1'b1;
                min_idx_next      = MY_IDX;
                min_cnt_next      = cnt_reg;
                min_page_next     = page_reg;
            end
        end
    end

    // Frame update: aging tick, fill on miss, mark on hit
    always_comb begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        cnt_next   = cnt_reg;
        page_next  = page_reg;
        if (cmd.tick && active && valid_reg) begin
            cnt_next = {ref_reg, cnt_reg[COUNTER_BITS-1:1]};
            ref_next = 1'b0;
        end
        if (cmd.fill && selected) begin
            valid_next = 1'b1;
            ref_next   = 1'b1;
            cnt_next   = '0;
            page_next  = cmd_page;
        end
        if (cmd.mark && selected) begin
            ref_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ref_reg   <= 1'b0;
            cnt_reg   <= '0;
            pf_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            cnt_reg   <= cnt_next;
            pf_reg    <= pf_next;
        end
    end

    // Page tag and probe payload need no reset
    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        pp_reg       <= pp_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        min_idx_reg  <= min_idx_next;
        min_cnt_reg  <= min_cnt_next;
        min_page_reg <= min_page_next;
    end

    assign probe_flags_o    = pf_reg;
    assign probe_page_o     = pp_reg;
    assign probe_hit_idx_o  = hit_idx_reg;
    assign probe_free_idx_o = free_idx_reg;
    assign probe_min_idx_o  = min_idx_reg;
    assign probe_min_cnt_o  = min_cnt_reg;
    assign probe_min_page_o = min_page_reg;

endmodule

// ===== rtl/aging_page_replacement_core.sv =====
// Top level: controller, result register and the chain of frame cells.
`timescale 1ns / 1ps

// Aging page replacement over a fully associative table of FRAMES frames.
// Input channel (s_valid/s_ready/s_data): each transaction is a page access
// or an aging tick. Result channel (m_valid/m_ready/m_data): one transaction
// per access, none per tick. cfg_wr_en/cfg_wr_data write the active frame
// count; write it only while the block is idle.
// An access launches a lookup that passes down the chain of frame cells,
// one cell per cycle. The tail's outcome is registered as a decision in
// the search state, the commit state then registers the result, and no
// input is taken until the controller is back in the idle state. A tick
// leaves the controller idle, so the next transaction can follow at once.
// The result sits in an output register; a stalled receiver holds it there
// while the next transaction is taken and looked up. A finished lookup waits
// for that register to drain before its result and table update are made.
// Reset (synchronous, active low) empties every frame, clears the hit and
// miss counts and sets the active frame count to 16. There is no clearing
// pass; the block accepts input as soon as reset is released.
module aging_page_replacement_core #(
    parameter int FRAMES       = apr_pkg::FRAMES_DEF,
    parameter int COUNTER_BITS = apr_pkg::COUNTER_BITS_DEF,
    parameter int PAGE_BITS    = apr_pkg::PAGE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [apr_pkg::ACTIVE_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  apr_pkg::access_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output apr_pkg::result_t               m_data
);
    import apr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int UW = (CW > ACTIVE_W) ? CW : ACTIVE_W;
    localparam logic [UW-1:0] FRAMES_U = UW'(FRAMES);
    localparam logic [UW-1:0] ONE_U    = UW'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [ACTIVE_W-1:0] active_frames_reg;
    logic [UW-1:0]       active_ext;
    logic [UW-1:0]       used_frames;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_frames_reg <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            active_frames_reg <= cfg_wr_data;
        end
    end

    // Zero counts as one frame, anything above the build size as the build size
    assign active_ext  = UW'(active_frames_reg);
    assign used_frames = (active_ext == '0) ? ONE_U :
                         ((active_ext > FRAMES_U) ? FRAMES_U : active_ext);

    // Chain wiring, entry 0 fed from the controller
    probe_flags_t            pr_flags    [0:FRAMES];
    logic [PAGE_BITS-1:0]    pr_page     [0:FRAMES];
    logic [IW-1:0]           pr_hit_idx  [0:FRAMES];
    logic [IW-1:0]           pr_free_idx [0:FRAMES];
    logic [IW-1:0]           pr_min_idx  [0:FRAMES];
    logic [COUNTER_BITS-1:0] pr_min_cnt  [0:FRAMES];
    logic [PAGE_BITS-1:0]    pr_min_page [0:FRAMES];
    logic [FRAMES:0]         pr_valid_vec;

    probe_flags_t         probe_flags_reg, probe_flags_next;
    logic [PAGE_BITS-1:0] probe_page_reg, probe_page_next;

    cell_cmd_t            cmd_reg, cmd_next;
    logic [IW-1:0]        cmd_slot_reg, cmd_slot_next;
    logic [PAGE_BITS-1:0] cmd_page_reg, cmd_page_next;

    assign pr_flags[0]    = probe_flags_reg;
    assign pr_page[0]     = probe_page_reg;
    assign pr_hit_idx[0]  = '0;
    assign pr_free_idx[0] = '0;
    assign pr_min_idx[0]  = '0;
    assign pr_min_cnt[0]  = '0;
    assign pr_min_page[0] = '0;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            apr_cell #(
                .INDEX        (g),
                .FRAMES       (FRAMES),
                .COUNTER_BITS (COUNTER_BITS),
                .PAGE_BITS    (PAGE_BITS),
                .IW           (IW),
                .UW           (UW)
            ) u_cell (
                .aclk             (aclk),
                .aresetn          (aresetn),
                .used_frames      (used_frames),
                .cmd              (cmd_reg),
                .cmd_slot         (cmd_slot_reg),
                .cmd_page         (cmd_page_reg),
                .probe_flags_i    (pr_flags[g]),
                .probe_page_i     (pr_page[g]),
                .probe_hit_idx_i  (pr_hit_idx[g]),
                .probe_free_idx_i (pr_free_idx[g]),
                .probe_min_idx_i  (pr_min_idx[g]),
                .probe_min_cnt_i  (pr_min_cnt[g]),
                .probe_min_page_i (pr_min_page[g]),
                .probe_flags_o    (pr_flags[g+1]),
                .probe_page_o     (pr_page[g+1]),
                .probe_hit_idx_o  (pr_hit_idx[g+1]),
                .probe_free_idx_o (pr_free_idx[g+1]),
                .probe_min_idx_o  (pr_min_idx[g+1]),
                .probe_min_cnt_o  (pr_min_cnt[g+1]),
                .probe_min_page_o (pr_min_page[g+1])
            );
        end
        for (g = 0; g <= FRAMES; g++) begin : g_vld
            assign pr_valid_vec[g] = pr_flags[g].valid;
        end
    endgenerate

    // Decision taken from the chain tail
    logic                 dec_hit_reg, dec_hit_next;
    logic                 dec_evict_reg, dec_evict_next;
    logic [IW-1:0]        dec_slot_reg, dec_slot_next;
    logic [PAGE_BITS-1:0] dec_page_reg, dec_page_next;
    logic [PAGE_BITS-1:0] dec_old_reg, dec_old_next;

    // Running totals and result register
    logic [COUNT_W-1:0] hits_total_reg, hits_total_next;
    logic [COUNT_W-1:0] misses_total_reg, misses_total_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_data_reg, m_data_next;

    probe_flags_t tail;
    logic         s_fire;
    logic         out_free;

    assign tail     = pr_flags[FRAMES];
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Controller
    always_comb begin
        state_next        = state_reg;
        probe_flags_next  = '0;
        probe_page_next   = probe_page_reg;
        cmd_next          = '0;
        cmd_slot_next     = cmd_slot_reg;
        cmd_page_next     = cmd_page_reg;
        dec_hit_next      = dec_hit_reg;
        dec_evict_next    = dec_evict_reg;
        dec_slot_next     = dec_slot_reg;
        dec_page_next     = dec_page_reg;
        dec_old_next      = dec_old_reg;
        hits_total_next   = hits_total_reg;
        misses_total_next = misses_total_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.cmd == CMD_TICK) begin
                        cmd_next.tick = 1'b1;
                    end else begin
                        probe_flags_next.valid = 1'b1;
                        probe_page_next        = PAGE_BITS'(s_data.page_number);
                        state_next             = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (tail.valid) begin
                    dec_hit_next   = tail.hit;
                    dec_evict_next = !tail.hit && !tail.free_found;
                    dec_page_next  = pr_page[FRAMES];
                    dec_old_next   = '0;
                    if (tail.hit) begin
                        dec_slot_next = pr_hit_idx[FRAMES];
                    end else if (tail.free_found) begin
                        dec_slot_next = pr_free_idx[FRAMES];
                    end else begin
                        dec_slot_next = pr_min_idx[FRAMES];
                        dec_old_next  = pr_min_page[FRAMES];
                    end
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    if (dec_hit_reg) begin
                        cmd_next.mark = 1'b1;
                        if (hits_total_reg != '1) begin
                            hits_total_next = hits_total_reg + COUNT_W'(1);
                        end
                    end else begin
                        cmd_next.fill = 1'b1;
                        if (misses_total_reg != '1) begin
                            misses_total_next = misses_total_reg + COUNT_W'(1);
                        end
                    end
                    cmd_slot_next            = dec_slot_reg;
                    cmd_page_next            = dec_page_reg;
                    m_valid_next             = 1'b1;
                    m_data_next.hit          = dec_hit_reg;
                    m_data_next.frame        = FRAME_W'(dec_slot_reg);
                    m_data_next.evicted      = dec_evict_reg;
                    m_data_next.evicted_page = PAGE_IN_W'(dec_old_reg);
                    m_data_next.hit_count    = hits_total_next;
                    m_data_next.miss_count   = misses_total_next;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            probe_flags_reg  <= '0;
            cmd_reg          <= '0;
            hits_total_reg   <= '0;
            misses_total_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            probe_flags_reg  <= probe_flags_next;
            cmd_reg          <= cmd_next;
            hits_total_reg   <= hits_total_next;
            misses_total_reg <= misses_total_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_page_reg <= probe_page_next;
        cmd_slot_reg   <= cmd_slot_next;
        cmd_page_reg   <= cmd_page_next;
        dec_hit_reg    <= dec_hit_next;
        dec_evict_reg  <= dec_evict_next;
        dec_slot_reg   <= dec_slot_next;
        dec_page_reg   <= dec_page_next;
        dec_old_reg    <= dec_old_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // At most one lookup in the chain at any time
    a_one_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(pr_valid_vec) <= 1)
        else $error("more than one lookup in the cell chain");

    // A lookup leaves the chain only while the controller waits for it
    a_tail_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == ST_SEARCH))
        else $error("lookup finished outside the search state");

    // A tick never coincides with a fill or a mark
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd_reg.tick, cmd_reg.fill, cmd_reg.mark}))
        else $error("conflicting frame updates");

    // Each commit issues exactly one table update in the next cycle
    a_commit_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && out_free) |=> (cmd_reg.fill || cmd_reg.mark))
        else $error("commit without a table update");

    // The running totals never go down
    a_totals_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (hits_total_reg >= $past(hits_total_reg) &&
             misses_total_reg >= $past(misses_total_reg)))
        else $error("hit or miss total decreased");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the aging page replacement core: driver, monitor and frame table predictor.
`timescale 1ns / 1ps

module tb_top;
    import apr_pkg::*;

    localparam int NFRAMES   = FRAMES_DEF;
    localparam int CNT_W     = COUNTER_BITS_DEF;
    localparam int SETTLE    = 2 * (NFRAMES + 3) + 2;
    localparam int MAX_CYCLE = 1000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [ACTIVE_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    access_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_t m_data;

    // Transactions waiting to be sent, and results the predictor expects
    access_t access_backlog[$];
    result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    // Predictor copy of the frame table
    logic              slot_valid[NFRAMES];
    logic              slot_ref[NFRAMES];
    logic [CNT_W-1:0]  slot_age[NFRAMES];
    logic [31:0]       slot_page[NFRAMES];
    logic [31:0]       hits_seen;
    logic [31:0]       misses_seen;
    logic [ACTIVE_W-1:0] active_reg;

    aging_page_replacement_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("aging_page_replacement_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t %s: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Frames searched, filled and aged under the current register value
    function automatic int frames_in_use();
        if (active_reg == 0)
            return 1;
        if (active_reg > NFRAMES)
            return NFRAMES;
        return int'(active_reg);
    endfunction

    function automatic void predictor_reset();
        for (int i = 0; i < NFRAMES; i++) begin
            slot_valid[i] = 1'b0;
            slot_ref[i]   = 1'b0;
            slot_age[i]   = '0;
            slot_page[i]  = '0;
        end
        hits_seen   = '0;
        misses_seen = '0;
        active_reg  = ACTIVE_RESET;
    endfunction

    // Apply one accepted transaction to the table; queue the result of an access
    function automatic void replace_predict(input access_t t);
        int n;
        int slot;
        bit hit_f;
        bit free_f;
        logic [CNT_W-1:0] best;
        result_t r;
        n = frames_in_use();
        if (t.cmd == CMD_TICK) begin
            for (int i = 0; i < n; i++) begin
                if (slot_valid[i]) begin
                    slot_age[i] = {slot_ref[i], slot_age[i][CNT_W-1:1]};
                    slot_ref[i] = 1'b0;
                end
            end
            return;
        end
        r = '0;
        hit_f = 1'b0;
        slot = 0;
        for (int i = 0; i < n; i++) begin
            if (!hit_f && slot_valid[i] && slot_page[i] == t.page_number) begin
                hit_f = 1'b1;
                slot = i;
            end
        end
        if (hit_f) begin
            if (hits_seen != '1)
                hits_seen++;
        end else begin
            if (misses_seen != '1)
                misses_seen++;
            free_f = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!free_f && !slot_valid[i]) begin
                    free_f = 1'b1;
                    slot = i;
                end
            end
            // No free frame: evict the oldest, lowest index on a tie
            if (!free_f) begin
                best = slot_age[0];
                slot = 0;
                for (int i = 1; i < n; i++) begin
                    if (slot_age[i] < best) begin
                        best = slot_age[i];
                        slot = i;
                    end
                end
                r.evicted      = 1'b1;
                r.evicted_page = slot_page[slot];
            end
            slot_valid[slot] = 1'b1;
            slot_page[slot]  = t.page_number;
            slot_age[slot]   = '0;
        end
        slot_ref[slot] = 1'b1;
        r.hit        = hit_f;
        r.frame      = FRAME_W'(slot);
        r.hit_count  = hits_seen;
        r.miss_count = misses_seen;
        pending_results.push_back(r);
    endfunction

    // Driver: predicts each accepted transaction, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                replace_predict(s_data);
            if (!s_valid || s_ready) begin
                if (access_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= access_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", m_data.hit_count, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.hit !== want.hit)
                    report_mismatch("hit", 32'(m_data.hit), 32'(want.hit));
                if (m_data.frame !== want.frame)
                    report_mismatch("frame", 32'(m_data.frame), 32'(want.frame));
                if (m_data.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(m_data.evicted), 32'(want.evicted));
                if (m_data.evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", m_data.evicted_page, want.evicted_page);
                if (m_data.hit_count !== want.hit_count)
                    report_mismatch("hit_count", m_data.hit_count, want.hit_count);
                if (m_data.miss_count !== want.miss_count)
                    report_mismatch("miss_count", m_data.miss_count, want.miss_count);
            end
        end
    end

    task automatic push_access(input logic [31:0] page);
        access_t t;
        t.cmd = CMD_ACCESS;
        t.page_number = page;
        access_backlog.push_back(t);
    endtask

    task automatic push_tick();
        access_t t;
        t.cmd = CMD_TICK;
        t.page_number = $urandom();
        access_backlog.push_back(t);
    endtask

    // Hold the sender until all results are in and the core has settled
    task automatic wait_drained();
        while (access_backlog.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_reg = value;
    endtask

    // Random traffic over a working set of the active frames plus up to six pages
    task automatic fill_random(input int count);
        logic [31:0] pool[$];
        int n_pool;
        int roll;
        int pick;
        n_pool = frames_in_use() + $urandom_range(0, 6);
        for (int k = 0; k < n_pool; k++)
            pool.push_back(($urandom_range(3) == 0) ? 32'($urandom_range(15)) : $urandom());
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            pick = $urandom_range(n_pool - 1);
            if (roll < 15) begin
                push_tick();
            end else if (roll < 80) begin
                push_access(pool[pick]);
            end else if (roll < 92) begin
                // working set drifts: forces evictions
                pool[pick] = $urandom();
                push_access(pool[pick]);
            end else begin
                push_access($urandom());
            end
        end
    endtask

    task automatic random_phase(input logic [ACTIVE_W-1:0] active, input int idle_pct,
                                input int stall_pct, input int count);
        wait_drained();
        write_active(active);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        fill_random(count);
    endtask

    // Main sequence
    initial begin
        predictor_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Two frames: fill, hit, tie on eviction, eviction by age
        write_active(5'd2);
        push_access(32'h0000_0000);
        push_access(32'hFFFF_FFFF);
        push_access(32'h0000_0000);
        push_tick();
        push_access(32'hA5A5_A5A5);
        push_tick();
        push_access(32'h5A5A_5A5A);
        push_access(32'h5A5A_5A5A);

        // Zero taken as one frame; frame one keeps its page while inactive
        wait_drained();
        write_active(5'd0);
        push_access(32'h1234_5678);
        push_tick();
        push_access(32'h5A5A_5A5A);

        // Above the built count: duplicate page, lowest frame hits
        wait_drained();
        write_active(5'd31);
        push_access(32'h5A5A_5A5A);
        push_access(32'h0000_FFFF);
        push_tick();

        random_phase(5'd16, 0, 0, 300);
        random_phase(5'd4, 62, 0, 250);
        random_phase(5'd1, 0, 62, 150);
        random_phase(5'd31, 22, 22, 300);
        random_phase(ACTIVE_W'($urandom_range(31)), 62, 0, 200);
        random_phase(5'd8, 0, 62, 200);
        random_phase(ACTIVE_W'($urandom_range(31)), 22, 22, 250);
        wait_drained();

        if (err_count == 0) begin
            $display("aging_page_replacement_core test passed");
        end else begin
            $display("aging_page_replacement_core test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/apr_pkg.sv
rtl/apr_cell.sv
rtl/aging_page_replacement_core.sv
bench/tb_top.sv
